>>> rtl/itp_pkg.sv
// Shared types and constants for the indented token tree parser.
// No dependencies; every other file refers to it by scoped names.
package itp_pkg;

	// Scan phase of the current line
	typedef enum logic [4:0] {
		PH_INDENT  = 5'b00001,
		PH_BARE    = 5'b00010,
		PH_QUOTED  = 5'b00100,
		PH_GAP     = 5'b01000,
		PH_COMMENT = 5'b10000
	} phase_t;

	// Per-beat sequencer
	typedef enum logic [3:0] {
		SEQ_IDLE    = 4'b0001,
		SEQ_POP_RD  = 4'b0010,
		SEQ_POP_CMP = 4'b0100,
		SEQ_FIN     = 4'b1000
	} seq_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_TABS   = 2'd1,
		KIND_SPACES = 2'd2
	} kind_t;

	// Control from the sequencer to the indentation stack
	typedef struct packed {
		logic rd;
		logic pop;
		logic push;
		logic clr;
	} stk_ctrl_t;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BTICK  = 8'h60;
	localparam logic [7:0] BOM_0     = 8'hEF;
	localparam logic [7:0] BOM_1     = 8'hBB;
	localparam logic [7:0] BOM_2     = 8'hBF;
	localparam logic [1:0] BOM_DONE  = 2'd3;
	localparam logic [19:0] LINE_MAX = 20'hFFFFF;
	localparam logic [4:0] DEPTH_CAP = 5'd31;

endpackage

>>> rtl/itp_stack.sv
// Indentation stack: entry memory, size counter and the shared compare
// unit used to pop ancestors one entry at a time. Uses itp_pkg.
module itp_stack #(
	parameter int MAX_DEPTH   = 16,
	parameter int INDENT_BITS = 8,
	localparam int SW = $clog2(MAX_DEPTH + 1),
	localparam int AW = $clog2(MAX_DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  itp_pkg::stk_ctrl_t     ctrl,
	input  logic [INDENT_BITS-1:0] indent,
	output logic [SW-1:0]          size,
	output logic                   ge
);

	logic [INDENT_BITS-1:0] mem [MAX_DEPTH];
	logic [INDENT_BITS-1:0] rd_q;
	logic [SW-1:0]          size_q;

	always_ff @(posedge clk) begin
		if (ctrl.push)
			mem[AW'(size_q)] <= indent;
		if (ctrl.rd)
			rd_q <= mem[AW'(size_q - 1'b1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
		end else if (ctrl.clr) begin
			size_q <= '0;
		end else if (ctrl.pop) begin
			size_q <= size_q - 1'b1;
		end else if (ctrl.push) begin
			size_q <= size_q + 1'b1;
		end
	end

	assign size = size_q;
	assign ge   = (rd_q >= indent);

endmodule

>>> rtl/indented_token_tree_parser.sv
// Top level of the indented token tree parser: byte scanner and sequencer.
// Depends on itp_pkg and itp_stack.
//
// Usage: feed the file one byte per beat on text_byte/end_of_file with
// text_valid/text_ready. Each input beat gives exactly one result beat on
// result_valid/result_ready carrying token, node and warning flags.
// Raise end_of_file on the final byte; a newline is implied after it and
// all scanner state returns to its reset value, so another file may follow.
// Sequence: a byte that does not open a node is captured, then finished.
// A byte that opens a node walks the indentation stack through a single
// compare unit, reading each stack entry and then comparing it, and pops
// at most MAX_DEPTH entries; the walk stops when it empties the stack or
// when a shallower entry is found.
// The stack memory has one registered read port.
// Results sit in an output register; when the receiver stalls the block
// still takes the next byte and holds its finished result until the
// register frees. Reset (arst_n low) clears the scanner to file start and
// empties the stack; stack contents need no clearing.
module indented_token_tree_parser #(
	parameter int MAX_DEPTH   = 16,
	parameter int INDENT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_file,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  out_byte,
	output logic        token_byte,
	output logic        token_begin,
	output logic        token_end,
	output logic        node_begin,
	output logic [4:0]  node_depth,
	output logic [19:0] line_count,
	output logic        mixed_indent,
	output logic        open_quote,
	output logic        depth_overflow,
	output logic        last_result
);

	localparam int SW = $clog2(MAX_DEPTH + 1);
	localparam logic [INDENT_BITS-1:0] INDENT_MAX = '1;

	itp_pkg::seq_t   seq_q;
	itp_pkg::phase_t ph_q, n_ph;
	itp_pkg::kind_t  kind_q, n_kind;
	logic [1:0]             bom_q, n_bom;
	logic [INDENT_BITS-1:0] icnt_q, n_icnt;
	logic                   mix_q, n_mix;
	logic [7:0]             qch_q, n_qch;
	logic [19:0]            ln_q, n_ln;
	logic [7:0]             byte_q;
	logic                   eof_q;

	itp_pkg::stk_ctrl_t ctrl;
	logic [SW-1:0]      size;
	logic               ge;

	logic skip_in, need_node, skip, fin_go, push_c;
	logic r_tbyte, r_tbeg, r_tend, r_node, r_mix, r_unc, r_ovf;
	logic [4:0] r_depth;
	logic [19:0] lc;

	itp_stack #(
		.MAX_DEPTH  (MAX_DEPTH),
		.INDENT_BITS(INDENT_BITS)
	) u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.indent(icnt_q),
		.size  (size),
		.ge    (ge)
	);

	assign text_ready = (seq_q == itp_pkg::SEQ_IDLE);
	assign fin_go = (seq_q == itp_pkg::SEQ_FIN) && (!result_valid || result_ready);

	// Node test on the incoming byte; scanner state is settled in idle
	assign skip_in = (bom_q == 2'd0 && text_byte == itp_pkg::BOM_0) ||
		(bom_q == 2'd1 && text_byte == itp_pkg::BOM_1) ||
		(bom_q == 2'd2 && text_byte == itp_pkg::BOM_2);
	assign need_node = !skip_in && (ph_q == itp_pkg::PH_INDENT) &&
		(text_byte > itp_pkg::CH_SPACE) && (text_byte != itp_pkg::CH_HASH);

	assign skip = (bom_q == 2'd0 && byte_q == itp_pkg::BOM_0) ||
		(bom_q == 2'd1 && byte_q == itp_pkg::BOM_1) ||
		(bom_q == 2'd2 && byte_q == itp_pkg::BOM_2);

	assign lc = (ln_q == itp_pkg::LINE_MAX) ? itp_pkg::LINE_MAX : ln_q + 20'd1;

	always_comb begin
		ctrl.rd   = (seq_q == itp_pkg::SEQ_POP_RD) && (size != '0);
		ctrl.pop  = (seq_q == itp_pkg::SEQ_POP_CMP) && ge;
		ctrl.push = fin_go && push_c && !eof_q;
		ctrl.clr  = fin_go && eof_q;
	end

	// Scan the held byte, then the implied newline on the last byte
	always_comb begin
		n_ph    = ph_q;
		n_kind  = kind_q;
		n_icnt  = icnt_q;
		n_mix   = mix_q;
		n_qch   = qch_q;
		n_ln    = ln_q;
		n_bom   = skip ? bom_q + 2'd1 : itp_pkg::BOM_DONE;
		r_tbyte = 1'b0;
		r_tbeg  = 1'b0;
		r_tend  = 1'b0;
		r_node  = 1'b0;
		r_mix   = 1'b0;
		r_unc   = 1'b0;
		r_ovf   = 1'b0;
		r_depth = '0;
		push_c  = 1'b0;
		if (!skip) begin
			unique case (ph_q)
				itp_pkg::PH_INDENT: begin
					if (byte_q == itp_pkg::CH_NL) begin
						n_ph = itp_pkg::PH_INDENT;
					end else if (byte_q <= itp_pkg::CH_SPACE) begin
						if (kind_q == itp_pkg::KIND_NONE) begin
							if (byte_q == itp_pkg::CH_TAB)
								n_kind = itp_pkg::KIND_TABS;
							else if (byte_q == itp_pkg::CH_SPACE)
								n_kind = itp_pkg::KIND_SPACES;
						end else if ((kind_q == itp_pkg::KIND_TABS &&
								byte_q != itp_pkg::CH_TAB) ||
								(kind_q == itp_pkg::KIND_SPACES &&
								byte_q != itp_pkg::CH_SPACE)) begin
							n_mix = 1'b1;
						end
						if (icnt_q != INDENT_MAX)
							n_icnt = icnt_q + 1'b1;
					end else if (byte_q == itp_pkg::CH_HASH) begin
						n_ph = itp_pkg::PH_COMMENT;
					end else begin
						r_node  = 1'b1;
						r_depth = (32'(size) > 32'd31) ? itp_pkg::DEPTH_CAP : 5'(size);
						if (size == SW'(MAX_DEPTH))
							r_ovf = 1'b1;
						else
							push_c = 1'b1;
						r_tbeg = 1'b1;
						if (byte_q == itp_pkg::CH_DQUOTE || byte_q == itp_pkg::CH_BTICK) begin
							n_qch = byte_q;
							n_ph  = itp_pkg::PH_QUOTED;
						end else begin
							r_tbyte = 1'b1;
							n_ph    = itp_pkg::PH_BARE;
						end
					end
				end
				itp_pkg::PH_BARE: begin
					if (byte_q == itp_pkg::CH_NL) begin
						r_tend = 1'b1;
						r_mix  = mix_q;
					end else if (byte_q <= itp_pkg::CH_SPACE) begin
						r_tend = 1'b1;
						n_ph   = itp_pkg::PH_GAP;
					end else begin
						r_tbyte = 1'b1;
					end
				end
				itp_pkg::PH_QUOTED: begin
					if (byte_q == itp_pkg::CH_NL) begin
						r_tend = 1'b1;
						r_unc  = 1'b1;
						r_mix  = mix_q;
					end else if (byte_q == qch_q) begin
						r_tend = 1'b1;
						n_qch  = '0;
						n_ph   = itp_pkg::PH_GAP;
					end else begin
						r_tbyte = 1'b1;
					end
				end
				itp_pkg::PH_GAP: begin
					if (byte_q == itp_pkg::CH_NL) begin
						r_mix = mix_q;
					end else if (byte_q == itp_pkg::CH_HASH) begin
						n_ph = itp_pkg::PH_COMMENT;
					end else if (byte_q > itp_pkg::CH_SPACE) begin
						r_tbeg = 1'b1;
						if (byte_q == itp_pkg::CH_DQUOTE || byte_q == itp_pkg::CH_BTICK) begin
							n_qch = byte_q;
							n_ph  = itp_pkg::PH_QUOTED;
						end else begin
							r_tbyte = 1'b1;
							n_ph    = itp_pkg::PH_BARE;
						end
					end
				end
				itp_pkg::PH_COMMENT: begin
					if (byte_q == itp_pkg::CH_NL)
						r_mix = mix_q;
				end
				default: ;
			endcase
			// Close the line on a newline in any phase
			if (byte_q == itp_pkg::CH_NL) begin
				n_ph   = itp_pkg::PH_INDENT;
				n_icnt = '0;
				n_mix  = 1'b0;
				n_qch  = '0;
				if (ln_q != itp_pkg::LINE_MAX)
					n_ln = ln_q + 20'd1;
			end
		end
		if (eof_q && (skip || byte_q != itp_pkg::CH_NL)) begin
			if (n_ph == itp_pkg::PH_BARE) begin
				r_tend = 1'b1;
				r_mix  = r_mix | n_mix;
			end else if (n_ph == itp_pkg::PH_QUOTED) begin
				r_tend = 1'b1;
				r_unc  = 1'b1;
				r_mix  = r_mix | n_mix;
			end else if (n_ph == itp_pkg::PH_GAP || n_ph == itp_pkg::PH_COMMENT) begin
				r_mix = r_mix | n_mix;
			end
		end
		// Drop all state at the end of the file
		if (eof_q) begin
			n_ph   = itp_pkg::PH_INDENT;
			n_kind = itp_pkg::KIND_NONE;
			n_icnt = '0;
			n_mix  = 1'b0;
			n_qch  = '0;
			n_ln   = '0;
			n_bom  = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && text_ready) begin
			byte_q <= text_byte;
			eof_q  <= end_of_file;
		end
		if (fin_go) begin
			out_byte       <= r_tbyte ? byte_q : 8'd0;
			token_byte     <= r_tbyte;
			token_begin    <= r_tbeg;
			token_end      <= r_tend;
			node_begin     <= r_node;
			node_depth     <= r_depth;
			line_count     <= lc;
			mixed_indent   <= r_mix;
			open_quote     <= r_unc;
			depth_overflow <= r_ovf;
			last_result    <= eof_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= itp_pkg::SEQ_IDLE;
			ph_q         <= itp_pkg::PH_INDENT;
			kind_q       <= itp_pkg::KIND_NONE;
			bom_q        <= 2'd0;
			icnt_q       <= '0;
			mix_q        <= 1'b0;
			qch_q        <= '0;
			ln_q         <= '0;
			result_valid <= 1'b0;
		end else begin
			if (result_valid && result_ready)
				result_valid <= 1'b0;
			unique case (seq_q)
				itp_pkg::SEQ_IDLE: begin
					if (text_valid)
						seq_q <= need_node ? itp_pkg::SEQ_POP_RD : itp_pkg::SEQ_FIN;
				end
				itp_pkg::SEQ_POP_RD: begin
					seq_q <= (size != '0) ? itp_pkg::SEQ_POP_CMP : itp_pkg::SEQ_FIN;
				end
				itp_pkg::SEQ_POP_CMP: begin
					seq_q <= ge ? itp_pkg::SEQ_POP_RD : itp_pkg::SEQ_FIN;
				end
				itp_pkg::SEQ_FIN: begin
					if (fin_go) begin
						seq_q        <= itp_pkg::SEQ_IDLE;
						result_valid <= 1'b1;
						ph_q         <= n_ph;
						kind_q       <= n_kind;
						bom_q        <= n_bom;
						icnt_q       <= n_icnt;
						mix_q        <= n_mix;
						qch_q        <= n_qch;
						ln_q         <= n_ln;
					end
				end
				default: seq_q <= itp_pkg::SEQ_IDLE;
			endcase
		end
	end

endmodule
